// ===== design/ppu_pkg.sv =====
// Package for the particle pool update unit: widths, command and kind codes,
// size clamp helper. Used by the update unit and by both testbench files.
package ppu_pkg;

    localparam int DEF_POOL_SIZE = 64;
    localparam int SLOT_W        = 6;
    localparam int COUNT_W       = 7;

    localparam logic [15:0] SIZE_FLOOR_RST   = 16'd256;
    localparam logic [15:0] SIZE_CEILING_RST = 16'd2560;

    localparam logic       CMD_EMIT = 1'b0;
    localparam logic       CMD_TICK = 1'b1;

    localparam logic [1:0] KIND_EMIT  = 2'd0;
    localparam logic [1:0] KIND_REC   = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam logic       CFG_FLOOR   = 1'b0;
    localparam logic       CFG_CEILING = 1'b1;

    // Clamp a requested size; with inverted bounds a size below the floor gets the floor, any other the ceiling.
    function automatic logic [15:0] clamp_size(input logic [15:0] sz,
                                               input logic [15:0] lo,
                                               input logic [15:0] hi);
        logic [15:0] r;
        r = sz;
        if (sz < lo)
        begin
            r = lo;
        end
        else if (sz > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

// ===== design/ppu_ram.sv =====
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
module ppu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/ppu_divider.sv =====
// Restoring divider, one quotient bit per cycle: 48-bit dividend, 32-bit divisor.
// Depends on nothing but the clock and reset.
module ppu_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);

    logic [47:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    // One shift-subtract step per cycle.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[31:0], quo_reg[47]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = busy_reg && (cnt_reg == 6'd47);
    assign quotient = quo_next;

endmodule

// ===== design/particle_pool_update_unit.sv =====
// Particle pool update unit: a sequencer around slot memories, one shared
// multiplier and a serial divider. Depends on ppu_pkg, ppu_ram and ppu_divider.
//
// An emit scans for the lowest free slot, then writes it. A tick works on each
// live slot with the 48-step alpha divider and passes through the shared 32x32
// multiplier, one per axis and one for alpha, plus a reporting pass with one
// result hand-over per live slot, and one pass over all slot flags. Every result
// waits in one output register and the walk pauses while it is not taken. No
// clearing pass is needed after reset; the block is ready as soon as reset is
// released.
module particle_pool_update_unit
    import ppu_pkg::*;
#(
    parameter int POOL_SIZE = DEF_POOL_SIZE
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic signed [31:0] speed_x,
    input  logic signed [31:0] speed_y,
    input  logic signed [31:0] speed_z,
    input  logic [23:0]        tint_rgb,
    input  logic [15:0]        tint_alpha,
    input  logic [15:0]        requested_size,
    input  logic [30:0]        lifetime,
    input  logic [30:0]        step_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic               accepted,
    output logic [5:0]         slot,
    output logic signed [31:0] now_x,
    output logic signed [31:0] now_y,
    output logic signed [31:0] now_z,
    output logic [15:0]        now_size,
    output logic [15:0]        now_alpha,
    output logic [23:0]        now_rgb,
    output logic [6:0]         live_total,
    output logic               final_res,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam logic [AW:0] LAST = (AW+1)'(POOL_SIZE - 1);

    // Sequencer states.
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_ESCAN = 5'd1;
    localparam logic [4:0] S_EOUT  = 5'd2;
    localparam logic [4:0] S_TNEXT = 5'd3;
    localparam logic [4:0] S_TRD   = 5'd4;
    localparam logic [4:0] S_TLIFE = 5'd5;
    localparam logic [4:0] S_TMUL  = 5'd6;
    localparam logic [4:0] S_TADD  = 5'd7;
    localparam logic [4:0] S_TAMUL = 5'd8;
    localparam logic [4:0] S_TDIV  = 5'd9;
    localparam logic [4:0] S_TWB   = 5'd10;
    localparam logic [4:0] S_RNEXT = 5'd11;
    localparam logic [4:0] S_RRD   = 5'd12;
    localparam logic [4:0] S_ROUT  = 5'd13;
    localparam logic [4:0] S_OWAIT = 5'd14;
    localparam logic [4:0] S_TDGO  = 5'd15;

    logic [4:0]  state_reg, state_next, ret_reg, ret_next;
    logic [15:0] floor_reg, ceiling_reg;
    logic [POOL_SIZE-1:0] live_reg, live_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next, rep_reg, rep_next;
    logic [AW:0]  idx_reg, idx_next;
    logic [1:0]   dim_reg, dim_next;
    logic [30:0]  step_reg;

    // Captured emit item.
    logic [95:0] e_place, e_motion;
    logic [23:0] e_rgb;
    logic [15:0] e_alpha, e_size;
    logic [30:0] e_life;

    // Slot memories.
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [95:0]   place_w, place_r, motion_r;
    logic [23:0]   rgb_r;
    logic [15:0]   alpha_w, alpha_r, size_r;
    logic [31:0]   life_w, life_r, init_r;
    logic          motion_we;

    // Working registers of the tick walk.
    logic signed [31:0] life_reg, life_next;
    logic [95:0] pos_reg, pos_next;
    logic [15:0] alpha_reg, alpha_next;
    logic signed [63:0] prod_reg;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_full;
    logic signed [48:0] sum;
    logic signed [31:0] sat;
    logic        div_start, div_done;
    logic [47:0] div_q;

    // Output register.
    logic        ov_reg;
    logic [1:0]  o_kind;
    logic        o_acc, o_fin;
    logic [5:0]  o_slot;
    logic [95:0] o_pos;
    logic [15:0] o_size, o_alpha;
    logic [23:0] o_rgb;
    logic [6:0]  o_total;
    logic        load_out;
    logic        in_fire, cfg_fire;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign we = (state_reg == S_ESCAN && idx_reg <= LAST && !live_reg[idx_reg[AW-1:0]])
                || (state_reg == S_TWB);
    assign motion_we = (state_reg == S_ESCAN);
    assign waddr   = idx_reg[AW-1:0];
    assign raddr   = idx_reg[AW-1:0];
    assign place_w = (state_reg == S_ESCAN) ? e_place : pos_reg;
    assign alpha_w = (state_reg == S_ESCAN) ? e_alpha : alpha_reg;
    assign life_w  = (state_reg == S_ESCAN) ? {1'b0, e_life} : life_reg;

    ppu_ram #(.WIDTH(96), .DEPTH(POOL_SIZE)) u_place (.clk, .we, .waddr,
        .wdata(place_w), .raddr, .rdata(place_r));
    ppu_ram #(.WIDTH(96), .DEPTH(POOL_SIZE)) u_motion (.clk, .we(we && motion_we),
        .waddr, .wdata(e_motion), .raddr, .rdata(motion_r));
    ppu_ram #(.WIDTH(24), .DEPTH(POOL_SIZE)) u_rgb (.clk, .we(we && motion_we),
        .waddr, .wdata(e_rgb), .raddr, .rdata(rgb_r));
    ppu_ram #(.WIDTH(16), .DEPTH(POOL_SIZE)) u_alpha (.clk, .we, .waddr,
        .wdata(alpha_w), .raddr, .rdata(alpha_r));
    ppu_ram #(.WIDTH(16), .DEPTH(POOL_SIZE)) u_size (.clk, .we(we && motion_we),
        .waddr, .wdata(e_size), .raddr, .rdata(size_r));
    ppu_ram #(.WIDTH(32), .DEPTH(POOL_SIZE)) u_life (.clk, .we, .waddr,
        .wdata(life_w), .raddr, .rdata(life_r));
    ppu_ram #(.WIDTH(32), .DEPTH(POOL_SIZE)) u_init (.clk, .we(we && motion_we),
        .waddr, .wdata({1'b0, e_life}), .raddr, .rdata(init_r));

    ppu_divider u_div (.clk, .rst_n, .start(div_start),
        .dividend({prod_reg[47:0]}), .divisor(init_r), .done(div_done),
        .quotient(div_q));

    // Shared multiplier: velocity by step, or alpha by remaining life.
    always_comb
    begin
        if (state_reg == S_TAMUL)
        begin
            mul_a = {17'd0, alpha_reg};
            mul_b = {1'b0, life_reg};
        end
        else
        begin
            mul_a = {motion_r[32*dim_reg +: 32][31], motion_r[32*dim_reg +: 32]};
            mul_b = {2'b00, step_reg};
        end
        mul_full = mul_a * mul_b;
    end

    // Position update with an arithmetic shift (floor) and saturation.
    always_comb
    begin
        sum = 49'(signed'(pos_reg[32*dim_reg +: 32])) + 49'(prod_reg >>> 16);
        if (sum > 49'sd2147483647)
        begin
            sat = 32'sh7FFFFFFF;
        end
        else if (sum < -49'sd2147483648)
        begin
            sat = 32'sh80000000;
        end
        else
        begin
            sat = sum[31:0];
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        live_next  = live_reg;
        cnt_next   = cnt_reg;
        rep_next   = rep_reg;
        idx_next   = idx_reg;
        dim_next   = dim_reg;
        life_next  = life_reg;
        pos_next   = pos_reg;
        alpha_next = alpha_reg;
        div_start  = 1'b0;
        load_out   = 1'b0;
        o_kind = KIND_EMIT; o_acc = 1'b0; o_slot = '0; o_pos = '0;
        o_size = '0; o_alpha = '0; o_rgb = '0; o_total = '0; o_fin = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                cnt_next = '0;
                if (in_fire)
                begin
                    state_next = (cmd == CMD_TICK) ? S_TNEXT : S_ESCAN;
                end
            end
            S_ESCAN:
            begin
                if (idx_reg > LAST)
                begin
                    load_out = 1'b1;
                    state_next = S_OWAIT;
                    ret_next = S_IDLE;
                end
                else if (!live_reg[idx_reg[AW-1:0]])
                begin
                    live_next[idx_reg[AW-1:0]] = 1'b1;
                    load_out = 1'b1;
                    o_acc  = 1'b1;
                    o_slot = 6'(idx_reg);
                    state_next = S_OWAIT;
                    ret_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_TNEXT:
            begin
                if (idx_reg > LAST)
                begin
                    idx_next = '0;
                    rep_next = '0;
                    if (cnt_reg == '0)
                    begin
                        load_out = 1'b1;
                        o_kind = KIND_EMPTY;
                        state_next = S_OWAIT;
                        ret_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RNEXT;
                    end
                end
                else if (live_reg[idx_reg[AW-1:0]])
                begin
                    state_next = S_TRD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_TRD:
            begin
                state_next = S_TLIFE;
            end
            S_TLIFE:
            begin
                life_next  = signed'(life_r) - signed'({1'b0, step_reg});
                pos_next   = place_r;
                alpha_next = alpha_r;
                dim_next   = '0;
                if (signed'(life_r) - signed'({1'b0, step_reg}) <= 0)
                begin
                    live_next[idx_reg[AW-1:0]] = 1'b0;
                    idx_next = idx_reg + 1'b1;
                    state_next = S_TNEXT;
                end
                else
                begin
                    state_next = S_TMUL;
                end
            end
            S_TMUL:
            begin
                state_next = S_TADD;
            end
            S_TADD:
            begin
                pos_next[32*dim_reg +: 32] = sat;
                if (dim_reg == 2'd2)
                begin
                    state_next = S_TAMUL;
                end
                else
                begin
                    dim_next = dim_reg + 2'd1;
                    state_next = S_TMUL;
                end
            end
            S_TAMUL:
            begin
                state_next = (init_r == '0) ? S_TWB : S_TDGO;
            end
            // The alpha product is in prod_reg from here on, so the divider
            // may take it.
            S_TDGO:
            begin
                div_start  = 1'b1;
                state_next = S_TDIV;
            end
            S_TDIV:
            begin
                if (div_done)
                begin
                    alpha_next = div_q[15:0];
                    state_next = S_TWB;
                end
            end
            S_TWB:
            begin
                cnt_next = cnt_reg + 1'b1;
                idx_next = idx_reg + 1'b1;
                state_next = S_TNEXT;
            end
            S_RNEXT:
            begin
                if (live_reg[idx_reg[AW-1:0]])
                begin
                    state_next = S_RRD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_RRD:
            begin
                state_next = S_ROUT;
            end
            S_ROUT:
            begin
                load_out = 1'b1;
                o_kind  = KIND_REC;
                o_slot  = 6'(idx_reg);
                o_pos   = place_r;
                o_size  = size_r;
                o_alpha = alpha_r;
                o_rgb   = rgb_r;
                o_total = cnt_reg;
                o_fin   = (rep_reg + 1'b1 == cnt_reg);
                rep_next = rep_reg + 1'b1;
                idx_next = idx_reg + 1'b1;
                state_next = S_OWAIT;
                ret_next = (rep_reg + 1'b1 == cnt_reg) ? S_IDLE : S_RNEXT;
            end
            S_OWAIT:
            begin
                if (out_ready)
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            live_reg    <= '0;
            cnt_reg     <= '0;
            rep_reg     <= '0;
            idx_reg     <= '0;
            dim_reg     <= '0;
            ov_reg      <= 1'b0;
            floor_reg   <= SIZE_FLOOR_RST;
            ceiling_reg <= SIZE_CEILING_RST;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            live_reg  <= live_next;
            cnt_reg   <= cnt_next;
            rep_reg   <= rep_next;
            idx_reg   <= idx_next;
            dim_reg   <= dim_next;
            if (load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (cfg_fire)
            begin
                if (cfg_index == CFG_FLOOR)
                begin
                    floor_reg <= cfg_data;
                end
                else
                begin
                    ceiling_reg <= cfg_data;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        life_reg  <= life_next;
        pos_reg   <= pos_next;
        alpha_reg <= alpha_next;
        prod_reg  <= mul_full[63:0];
        if (in_fire)
        begin
            step_reg <= step_time;
            e_place  <= {start_z, start_y, start_x};
            e_motion <= {speed_z, speed_y, speed_x};
            e_rgb    <= tint_rgb;
            e_alpha  <= tint_alpha;
            e_size   <= clamp_size(requested_size, floor_reg, ceiling_reg);
            e_life   <= lifetime;
        end
        if (load_out)
        begin
            kind       <= o_kind;
            accepted   <= o_acc;
            slot       <= o_slot;
            now_x      <= o_pos[31:0];
            now_y      <= o_pos[63:32];
            now_z      <= o_pos[95:64];
            now_size   <= o_size;
            now_alpha  <= o_alpha;
            now_rgb    <= o_rgb;
            live_total <= o_total;
            final_res  <= o_fin;
        end
    end

    assign out_valid = ov_reg;

    // The result register is only full while the sequencer waits on it.
    a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OWAIT)
        else $error("result pending outside the wait state");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= COUNT_W'(POOL_SIZE))
        else $error("live count beyond pool size");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready && !cfg_ready)
        else $error("ready while busy");

endmodule

// ===== test/particle_pool_checker.sv =====
// Checker for the particle pool update unit: mirrors the slot pool, predicts
// every result and compares it with what the block returns. Depends on ppu_pkg.
`timescale 1ns / 100ps

module particle_pool_checker
    import ppu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               cmd,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic signed [31:0] speed_x,
    input  logic signed [31:0] speed_y,
    input  logic signed [31:0] speed_z,
    input  logic [23:0]        tint_rgb,
    input  logic [15:0]        tint_alpha,
    input  logic [15:0]        requested_size,
    input  logic [30:0]        lifetime,
    input  logic [30:0]        step_time,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         kind,
    input  logic               accepted,
    input  logic [5:0]         slot,
    input  logic signed [31:0] now_x,
    input  logic signed [31:0] now_y,
    input  logic signed [31:0] now_z,
    input  logic [15:0]        now_size,
    input  logic [15:0]        now_alpha,
    input  logic [23:0]        now_rgb,
    input  logic [6:0]         live_total,
    input  logic               final_res,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 results_owed
);

    typedef struct packed {
        logic [1:0]  kind;
        logic        accepted;
        logic [5:0]  slot;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [15:0] size;
        logic [15:0] alpha;
        logic [23:0] rgb;
        logic [6:0]  total;
        logic        last;
    } pool_result_t;

    // Mirror of the pool and of the size bounds.
    logic [15:0]   floor_q, ceiling_q;
    logic          live [64];
    longint        place [64][3];
    longint        motion [64][3];
    logic [23:0]   rgb_q [64];
    longint        alpha_q [64];
    logic [15:0]   size_q [64];
    longint        life_q [64];
    longint        first_life [64];
    pool_result_t  pending_results [$];

    assign results_owed = pending_results.size();

    // Append one predicted result at the tail of the queue.
    task automatic add_expected(input pool_result_t r);
        pending_results = {pending_results, r};
    endtask

    // Handle one emit transaction: lowest free slot, or a rejection.
    task automatic place_particle();
        pool_result_t r;
        int           free_idx;
        logic [15:0]  sz;
        r = '0;
        r.last = 1'b1;
        free_idx = -1;
        for (int i = 0; i < 64; i++)
        begin
            if (!live[i] && free_idx < 0)
            begin
                free_idx = i;
            end
        end
        if (free_idx >= 0)
        begin
            place[free_idx][0] = longint'(start_x);
            place[free_idx][1] = longint'(start_y);
            place[free_idx][2] = longint'(start_z);
            motion[free_idx][0] = longint'(speed_x);
            motion[free_idx][1] = longint'(speed_y);
            motion[free_idx][2] = longint'(speed_z);
            rgb_q[free_idx] = tint_rgb;
            alpha_q[free_idx] = longint'(tint_alpha);
            sz = requested_size;
            if (sz < floor_q)
            begin
                sz = floor_q;
            end
            else if (sz > ceiling_q)
            begin
                sz = ceiling_q;
            end
            size_q[free_idx] = sz;
            life_q[free_idx] = longint'(lifetime);
            first_life[free_idx] = longint'(lifetime);
            live[free_idx] = 1'b1;
            r.accepted = 1'b1;
            r.slot = free_idx[5:0];
        end
        r.kind = KIND_EMIT;
        add_expected(r);
    endtask

    // Handle one tick transaction: age, move and fade every live particle.
    task automatic advance_pool();
        pool_result_t r;
        longint       step, moved;
        int           cnt, k;
        step = longint'(step_time);
        cnt = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (live[i])
            begin
                life_q[i] = life_q[i] - step;
                if (life_q[i] <= 0)
                begin
                    live[i] = 1'b0;
                end
                else
                begin
                    for (int d = 0; d < 3; d++)
                    begin
                        // Product is Q32.32; the arithmetic shift floors to Q16.16.
                        moved = place[i][d] + ((motion[i][d] * step) >>> 16);
                        if (moved > 64'sd2147483647)
                        begin
                            moved = 64'sd2147483647;
                        end
                        else if (moved < -64'sd2147483648)
                        begin
                            moved = -64'sd2147483648;
                        end
                        place[i][d] = moved;
                    end
                    if (first_life[i] > 0)
                    begin
                        alpha_q[i] = (alpha_q[i] * life_q[i]) / first_life[i];
                    end
                    cnt++;
                end
            end
        end
        if (cnt == 0)
        begin
            r = '0;
            r.kind = KIND_EMPTY;
            r.last = 1'b1;
            add_expected(r);
        end
        else
        begin
            k = 0;
            for (int i = 0; i < 64; i++)
            begin
                if (live[i])
                begin
                    r = '0;
                    r.kind = KIND_REC;
                    r.slot = i[5:0];
                    r.px = place[i][0][31:0];
                    r.py = place[i][1][31:0];
                    r.pz = place[i][2][31:0];
                    r.size = size_q[i];
                    r.alpha = alpha_q[i][15:0];
                    r.rgb = rgb_q[i];
                    r.total = cnt[6:0];
                    k++;
                    r.last = (k == cnt);
                    add_expected(r);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Watch the three channels on every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        pool_result_t e;
        if (!rst_n)
        begin
            floor_q <= SIZE_FLOOR_RST;
            ceiling_q <= SIZE_CEILING_RST;
            for (int i = 0; i < 64; i++)
            begin
                live[i] = 1'b0;
            end
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_FLOOR)
                begin
                    floor_q <= cfg_data;
                end
                else
                begin
                    ceiling_q <= cfg_data;
                end
            end
            if (in_valid && in_ready)
            begin
                if (cmd == CMD_EMIT)
                begin
                    place_particle();
                end
                else
                begin
                    advance_pool();
                end
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, kind %0d", $time, kind);
                    fail_count++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    check_field("kind", e.kind, kind);
                    check_field("accepted", e.accepted, accepted);
                    check_field("slot", e.slot, slot);
                    check_field("now_x", e.px, now_x);
                    check_field("now_y", e.py, now_y);
                    check_field("now_z", e.pz, now_z);
                    check_field("now_size", e.size, now_size);
                    check_field("now_alpha", e.alpha, now_alpha);
                    check_field("now_rgb", e.rgb, now_rgb);
                    check_field("live_total", e.total, live_total);
                    check_field("final_res", e.last, final_res);
                end
            end
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the particle pool update testbench: clock, reset and stimulus.
// Depends on ppu_pkg, particle_pool_update_unit and particle_pool_checker.
`timescale 1ns / 100ps

module tb_top;
    import ppu_pkg::*;

    localparam int STALL_LIMIT = 40000;

    logic               clk, rst_n;
    logic               in_valid, in_ready, cmd;
    logic signed [31:0] start_x, start_y, start_z, speed_x, speed_y, speed_z;
    logic [23:0]        tint_rgb;
    logic [15:0]        tint_alpha, requested_size;
    logic [30:0]        lifetime, step_time;
    logic               out_valid, out_ready;
    logic [1:0]         kind;
    logic               accepted, final_res;
    logic [5:0]         slot;
    logic signed [31:0] now_x, now_y, now_z;
    logic [15:0]        now_size, now_alpha;
    logic [23:0]        now_rgb;
    logic [6:0]         live_total;
    logic               cfg_valid, cfg_ready, cfg_index;
    logic [15:0]        cfg_data;
    int                 fail_count, results_owed;
    int                 sender_idle_pct, receiver_idle_pct;
    int                 quiet_cycles = 0;

    particle_pool_update_unit dut (.*);
    particle_pool_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver stalls at random.
    always @(posedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= receiver_idle_pct);
    end

    // Watchdog: too long without any transaction on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_item(input logic c, input logic [31:0] x, y, z, vx, vy, vz,
                             input logic [23:0] rgb, input logic [15:0] a, sz,
                             input logic [30:0] life, step);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        start_x <= x;
        start_y <= y;
        start_z <= z;
        speed_x <= vx;
        speed_y <= vy;
        speed_z <= vz;
        tint_rgb <= rgb;
        tint_alpha <= a;
        requested_size <= sz;
        lifetime <= life;
        step_time <= step;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic emit(input logic [31:0] x, y, z, vx, vy, vz, input logic [23:0] rgb,
                        input logic [15:0] a, sz, input logic [30:0] life);
        send_item(CMD_EMIT, x, y, z, vx, vy, vz, rgb, a, sz, life, 31'($urandom));
    endtask

    task automatic tick(input logic [30:0] step);
        send_item(CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  24'($urandom), 16'($urandom), 16'($urandom), 31'($urandom), step);
    endtask

    task automatic write_bound(input logic idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Let every owed result arrive before touching the bounds.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'h7FFF_0000 + $urandom_range(65535);
            2: return 32'h8000_0000 + $urandom_range(65535);
            default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
        endcase
    endfunction

    function automatic logic [30:0] pick_life();
        case ($urandom_range(9))
            0, 1: return 31'($urandom);
            2: return 31'($urandom_range(65535));
            default: return 31'($urandom_range(1 << 22, 1 << 16));
        endcase
    endfunction

    function automatic logic [30:0] pick_step();
        case ($urandom_range(9))
            0: return 31'd0;
            1: return 31'($urandom);
            2, 3: return 31'($urandom_range(1 << 18));
            default: return 31'($urandom_range(4096));
        endcase
    endfunction

    task automatic random_run(input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 65)
            begin
                emit(pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                     pick_coord(), 24'($urandom), 16'($urandom), 16'($urandom), pick_life());
            end
            else
            begin
                tick(pick_step());
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        cmd <= CMD_EMIT;
        {start_x, start_y, start_z, speed_x, speed_y, speed_z} <= '0;
        tint_rgb <= '0;
        tint_alpha <= '0;
        requested_size <= '0;
        lifetime <= '0;
        step_time <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_FLOOR;
        cfg_data <= '0;
        sender_idle_pct = 19;
        receiver_idle_pct = 48;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset bounds: empty tick, field extremes,
        // zero and tiny lifetimes, saturation both ways, and a full fade.
        tick(31'h7FFF_FFFF);
        emit(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h0001_0000, 24'hFF_FFFF, 16'hFFFF, 16'h0, 31'h7FFF_FFFF);
        emit(32'h0, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000,
             24'h0, 16'h0, 16'hFFFF, 31'd1);
        emit(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 32'hFFFF_0001, 32'h0000_FFFF,
             32'h0, 24'hA5_5A3C, 16'h8000, 16'd1000, 31'd0);
        emit(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
             24'h12_3456, 16'hFFFF, 16'd2560, 31'h0004_0000);
        tick(31'd0);
        tick(31'd1);
        tick(31'h0000_8000);
        tick(31'h0001_0000);
        emit(32'h7FFF_0000, 32'h8000_FFFF, 32'h0, 32'h0, 32'h0, 32'h0,
             24'h55_AA55, 16'h7FFF, 16'd256, 31'h0002_0000);
        tick(31'h0001_FFFF);
        tick(31'h7FFF_FFFF);
        drain();

        // Widest bounds.
        write_bound(CFG_FLOOR, 16'h0000);
        write_bound(CFG_CEILING, 16'hFFFF);
        random_run(130);
        drain();

        // Inverted bounds, roles of the two sides swapped.
        sender_idle_pct = 48;
        receiver_idle_pct = 19;
        write_bound(CFG_FLOOR, 16'd3000);
        write_bound(CFG_CEILING, 16'd1000);
        random_run(130);
        drain();

        // Full rate on both sides: narrowest extremes, then the reset bounds.
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        write_bound(CFG_FLOOR, 16'hFFFF);
        write_bound(CFG_CEILING, 16'h0000);
        random_run(60);
        drain();
        write_bound(CFG_FLOOR, 16'd256);
        write_bound(CFG_CEILING, 16'd2560);
        random_run(70);
        drain();

        repeat (50) @(posedge clk);
        if (fail_count == 0 && results_owed == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
